FILE: hw/rtl/mtp_pkg.sv
// Shared types, constants and helpers for the melody tone player.
`timescale 1ns / 1ps
`default_nettype none

package mtp_pkg;

  // Field widths
  localparam int unsigned NOTE_IDX_W = 6;
  localparam int unsigned FREQ_W     = 15;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PHASE_W    = 32;

  // Sine phase resolution (log2 of grid points per period)
  localparam int unsigned SINE_LOG2 = 10;
  localparam logic [PHASE_W-1:0] PHASE_MASK =
    ~((32'd1 << (PHASE_W - SINE_LOG2)) - 32'd1);

  // Request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  // Sound profiles (code 3 plays as sine)
  localparam logic [1:0] PROF_SINE   = 2'd0;
  localparam logic [1:0] PROF_RADIO  = 2'd1;
  localparam logic [1:0] PROF_SQUARE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 1'b1;

  localparam logic [1:0]        PROF_RESET = PROF_SINE;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd32767;

  // Q30 quarter-wave sine polynomial
  localparam logic [31:0] Q30_ONE = 32'd1073741824;
  localparam logic [31:0] SIN_A1  = 32'd1686629713;
  localparam logic [31:0] SIN_A3  = 32'd693598668;
  localparam logic [31:0] SIN_A5  = 32'd85569306;
  localparam logic [31:0] SIN_A7  = 32'd5026995;
  localparam logic [31:0] SIN_A9  = 32'd172273;

  // floor(x / 5) == (x * 52429) >> 18 for any 15-bit x
  localparam logic [15:0] DIV5_RECIP = 16'd52429;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  ms_tick;
    logic [NOTE_IDX_W-1:0] note_index;
    logic [FREQ_W-1:0]     note_frequency;
    logic [DUR_W-1:0]      note_duration_ms;
    logic [LEN_W-1:0]      melody_length;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       playing;
  } out_item_t;

  typedef enum logic [2:0] {
    MUL_X2,
    MUL_H9,
    MUL_H7,
    MUL_H5,
    MUL_H3,
    MUL_H1,
    MUL_AMP
  } mul_step_t;

  typedef struct packed {
    logic      load_item;
    logic      div_init;
    logic      div_step;
    logic      ram_wr;
    logic      start;
    logic      stop;
    logic      halt;
    logic      el_step;
    logic      adv;
    logic      el_clear;
    logic      rd_cur;
    logic      load_note;
    logic      mul_en;
    mul_step_t mul_sel;
    logic      emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       idx_ok;
    logic       playing;
    logic       cur_over;
    logic       div_last;
    logic       dur_reached;
    logic       note_end;
    logic       note_nz;
    logic       square;
  } dp_status_t;

  // 15-bit profile level: amplitude * 2 / 10
  function automatic logic [AMP_W-1:0] square_level(input logic [AMP_W-1:0] amp);
    logic [30:0] prod;
    prod = 31'(amp) * 31'(DIV5_RECIP);
    return AMP_W'(prod >> 18);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mtp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mtp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mtp_ctrl.sv
// Controller state machine: sequences requests through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module mtp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire mtp_pkg::dp_status_t st,
  output mtp_pkg::dp_cmd_t         cmd
);
  import mtp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_WR,
    S_DUR,
    S_ADV,
    S_FREQ,
    S_X2,
    S_H9,
    S_H7,
    S_H5,
    S_H3,
    S_H1,
    S_AMP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.kind)
          KIND_WRITE: begin
            if (st.idx_ok) begin
              cmd.div_init = 1'b1;
              state_nxt    = S_DIV;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          KIND_START: begin
            cmd.start = 1'b1;
            state_nxt = S_IDLE;
          end
          KIND_STOP: begin
            cmd.stop  = 1'b1;
            state_nxt = S_EMIT;
          end
          default: begin
            if (!st.playing) begin
              state_nxt = S_IDLE;
            end else if (st.cur_over) begin
              cmd.halt  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cmd.el_step = 1'b1;
              cmd.rd_cur  = 1'b1;
              state_nxt   = S_DUR;
            end
          end
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.ram_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DUR: begin
        if (st.dur_reached) begin
          cmd.adv   = 1'b1;
          state_nxt = S_ADV;
        end else begin
          state_nxt = S_FREQ;
        end
      end
      S_ADV: begin
        if (st.note_end) begin
          cmd.halt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.el_clear = 1'b1;
          cmd.rd_cur   = 1'b1;
          state_nxt    = S_FREQ;
        end
      end
      S_FREQ: begin
        cmd.load_note = 1'b1;
        if (!st.note_nz || st.square) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_X2;
        end
      end
      S_X2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X2;
        state_nxt   = S_H9;
      end
      S_H9: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_H9;
        state_nxt   = S_H7;
      end
      S_H7: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_H7;
        state_nxt   = S_H5;
      end
      S_H5: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_H5;
        state_nxt   = S_H3;
      end
      S_H3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_H3;
        state_nxt   = S_H1;
      end
      S_H1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_H1;
        state_nxt   = S_AMP;
      end
      S_AMP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AMP;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mtp_datapath.sv
// Datapath: note store, increment divider, phase accumulator and sine multiplier.
`timescale 1ns / 1ps
`default_nettype none

module mtp_datapath #(
  parameter int unsigned MAX_NOTES = 64,
  parameter int unsigned SAMPLE_HZ = 44100
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire mtp_pkg::in_item_t                in_data,
  input  wire logic                             cfg_we,
  input  wire logic [mtp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mtp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire mtp_pkg::dp_cmd_t                 cmd,
  output mtp_pkg::dp_status_t                   st,
  output mtp_pkg::out_item_t                    out_data
);
  import mtp_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_NOTES);
  localparam int unsigned CW     = $clog2(MAX_NOTES + 1);
  localparam int unsigned IXW    = (CW > NOTE_IDX_W) ? CW : NOTE_IDX_W;
  localparam int unsigned LXW    = (CW > LEN_W) ? CW : LEN_W;
  localparam int unsigned RAM_W  = 1 + PHASE_W + DUR_W;
  localparam int unsigned REM_W  = $clog2(SAMPLE_HZ) + FREQ_W;
  localparam int unsigned QUO_W  = FREQ_W;
  localparam int unsigned RCP_W  = FREQ_W + 1;
  localparam int unsigned EST_W  = REM_W + RCP_W;
  localparam int unsigned DCNT_W = 2;
  localparam int unsigned BASE_W = FREQ_W + PHASE_W;

  // increment = freq * floor(2^32/SR) + round(freq * (2^32 mod SR) / SR)
  localparam longint unsigned TWO32   = 64'h1_0000_0000;
  localparam longint unsigned INC_Q   = TWO32 / SAMPLE_HZ;
  localparam longint unsigned INC_R   = TWO32 % SAMPLE_HZ;
  localparam longint unsigned HALF_SR = SAMPLE_HZ / 2;

  // floor(2^REM_W / SR): the quotient estimate is low by at most one
  localparam longint unsigned RCP = (64'd1 << REM_W) / SAMPLE_HZ;

  // Divide steps: estimate, remainder, then the one-off correction
  localparam logic [DCNT_W-1:0] DIV_EST = 2'd2;
  localparam logic [DCNT_W-1:0] DIV_SUB = 2'd1;

  // Config
  logic [1:0]        prof_r;
  logic [AMP_W-1:0]  amp_r;

  // Sequencing state
  in_item_t          item_r;
  logic [PHASE_W-1:0] phase_r;
  logic [CW-1:0]     cur_r;
  logic [CW-1:0]     len_r;
  logic [DUR_W-1:0]  el_r;
  logic              playing_r;

  // Increment divider
  logic [REM_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [PHASE_W-1:0] base_r;

  // Sine evaluation
  logic [30:0]       x_r;
  logic              neg_r;
  logic [31:0]       x2_r;
  logic [31:0]       t_r;
  logic signed [SAMPLE_W-1:0] res_r;
  out_item_t         out_r;

  // Note store
  logic [IXW-1:0]    widx;
  logic [RAM_W-1:0]  wdata;
  logic [RAM_W-1:0]  rdata;
  logic              rd_nz;
  logic [PHASE_W-1:0] rd_inc;
  logic [DUR_W-1:0]  rd_dur;

  // Combinational helpers
  logic [REM_W-1:0]  div_x;
  logic [EST_W-1:0]  est_full;
  logic [REM_W-1:0]  sub_full;
  logic [BASE_W-1:0] base_full;
  logic [LXW-1:0]    mlen_x;
  logic [CW-1:0]     len_sat;
  logic [PHASE_W-1:0] u_phase;
  logic [29:0]       frac;
  logic [AMP_W-1:0]  sq_lvl;
  logic [31:0]       mul_a, mul_b, clamped;
  logic [63:0]       prod;
  logic [AMP_W-1:0]  mag, mag_prof;

  assign widx  = IXW'(item_r.note_index);
  assign wdata = {item_r.note_frequency != '0, base_r + PHASE_W'(quo_r),
                  item_r.note_duration_ms};

  mtp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_NOTES)
  ) u_note_ram (
    .clk   (clk),
    .we    (cmd.ram_wr),
    .waddr (widx[AW-1:0]),
    .wdata (wdata),
    .re    (cmd.rd_cur),
    .raddr (cur_r[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_nz  = rdata[RAM_W-1];
  assign rd_inc = rdata[DUR_W +: PHASE_W];
  assign rd_dur = rdata[DUR_W-1:0];

  assign div_x = REM_W'(item_r.note_frequency) * REM_W'(INC_R) + REM_W'(HALF_SR);
  assign base_full = BASE_W'(item_r.note_frequency) * BASE_W'(INC_Q);

  assign est_full = EST_W'(rem_r) * EST_W'(RCP);
  assign sub_full = REM_W'(quo_r) * REM_W'(SAMPLE_HZ);

  assign mlen_x  = LXW'(item_r.melody_length);
  assign len_sat = (mlen_x > LXW'(MAX_NOTES)) ? CW'(MAX_NOTES) : CW'(mlen_x);

  // Quantise to the sine phase grid and fold into the first quarter wave
  assign u_phase = phase_r & PHASE_MASK;
  assign frac    = u_phase[29:0];
  assign sq_lvl  = square_level(amp_r);

  assign clamped = (t_r > Q30_ONE) ? Q30_ONE : t_r;

  always_comb begin
    case (cmd.mul_sel)
      MUL_X2: begin
        mul_a = {1'b0, x_r};
        mul_b = {1'b0, x_r};
      end
      MUL_H9: begin
        mul_a = x2_r;
        mul_b = SIN_A9;
      end
      MUL_H7: begin
        mul_a = x2_r;
        mul_b = SIN_A7 - t_r;
      end
      MUL_H5: begin
        mul_a = x2_r;
        mul_b = SIN_A5 - t_r;
      end
      MUL_H3: begin
        mul_a = x2_r;
        mul_b = SIN_A3 - t_r;
      end
      MUL_H1: begin
        mul_a = {1'b0, x_r};
        mul_b = SIN_A1 - t_r;
      end
      MUL_AMP: begin
        mul_a = clamped;
        mul_b = 32'(amp_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign mag      = prod[30 +: AMP_W];
  assign mag_prof = (prof_r == PROF_RADIO) ? (mag >> 1) : mag;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prof_r    <= PROF_RESET;
      amp_r     <= AMP_RESET;
      phase_r   <= '0;
      cur_r     <= '0;
      len_r     <= '0;
      el_r      <= '0;
      playing_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROFILE:   prof_r <= cfg_data[1:0];
          CFG_AMPLITUDE: amp_r  <= cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        if (item_r.melody_length == '0) begin
          playing_r <= 1'b0;
        end else begin
          len_r     <= len_sat;
          cur_r     <= '0;
          el_r      <= '0;
          playing_r <= 1'b1;
        end
      end
      if (cmd.stop) begin
        playing_r <= 1'b0;
        len_r     <= '0;
        cur_r     <= '0;
        el_r      <= '0;
      end
      if (cmd.halt) begin
        playing_r <= 1'b0;
      end
      if (cmd.el_step && item_r.ms_tick && (el_r != '1)) begin
        el_r <= el_r + DUR_W'(1);
      end
      if (cmd.el_clear) begin
        el_r <= '0;
      end
      if (cmd.adv) begin
        cur_r <= cur_r + CW'(1);
      end
      if (cmd.load_note && rd_nz) begin
        phase_r <= phase_r + rd_inc;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.div_init) begin
      rem_r  <= div_x;
      quo_r  <= '0;
      dcnt_r <= DIV_EST;
      base_r <= base_full[PHASE_W-1:0];
    end
    if (cmd.div_step) begin
      case (dcnt_r)
        DIV_EST: quo_r <= est_full[REM_W +: QUO_W];
        DIV_SUB: rem_r <= rem_r - sub_full;
        default: begin
          if (rem_r >= REM_W'(SAMPLE_HZ)) begin
            quo_r <= quo_r + QUO_W'(1);
          end
        end
      endcase
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
    if (cmd.stop) begin
      res_r <= '0;
    end
    if (cmd.load_note) begin
      x_r   <= u_phase[30] ? (31'h4000_0000 - 31'(frac)) : 31'(frac);
      neg_r <= u_phase[31];
      if (!rd_nz) begin
        res_r <= '0;
      end else if (prof_r == PROF_SQUARE) begin
        res_r <= phase_r[31] ? -SAMPLE_W'(sq_lvl) : SAMPLE_W'(sq_lvl);
      end
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_X2:  x2_r  <= prod[61:30];
        MUL_AMP: res_r <= neg_r ? -SAMPLE_W'(mag_prof) : SAMPLE_W'(mag_prof);
        default: t_r   <= prod[61:30];
      endcase
    end
    if (cmd.emit) begin
      out_r.sample  <= res_r;
      out_r.playing <= playing_r;
    end
  end

  assign out_data = out_r;

  always_comb begin
    st             = '0;
    st.kind        = item_r.kind;
    st.idx_ok      = widx < IXW'(MAX_NOTES);
    st.playing     = playing_r;
    st.cur_over    = cur_r >= CW'(MAX_NOTES);
    st.div_last    = dcnt_r == '0;
    st.dur_reached = el_r >= rd_dur;
    st.note_end    = (cur_r >= len_r) || (cur_r >= CW'(MAX_NOTES));
    st.note_nz     = rd_nz;
    st.square      = prof_r == PROF_SQUARE;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/melody_tone_player_top.sv
// Top level of the melody tone player: controller, datapath and ports.
// Results: a tick that plays a note runs decode, duration check, note load,
//   the seven multiplier steps (sine/radio, not square or rest) and emit,
//   with an advance on a note change; stop emits; write and start give none.
// One request is in flight: a new one is taken only once the last is done.
// Reset: synchronous active-low rst_n clears sequencing state and config;
//   the note store is not cleared, so read only entries that were written.
`timescale 1ns / 1ps
`default_nettype none

module melody_tone_player_top #(
  parameter int unsigned MAX_NOTES = 64,
  parameter int unsigned SAMPLE_HZ = 44100
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input requests
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mtp_pkg::in_item_t              in_data,
  // Result requests
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mtp_pkg::out_item_t                  out_data,
  // Configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mtp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mtp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Config regs are plain flops; a write is always accepted.
  assign cfg_ready = 1'b1;

  // Controller: decodes each request and steps the datapath through the
  // divider, note lookup, polynomial and result hand-off. It also owns the
  // result valid so a held result never blocks the next input request.
  mtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: note RAM holding {nonzero, phase increment, duration}, the
  // three-step reciprocal divide used on note writes, the phase accumulator
  // and one 32x32 multiplier shared across the sine evaluation.
  mtp_datapath #(
    .MAX_NOTES (MAX_NOTES),
    .SAMPLE_HZ (SAMPLE_HZ)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/mtp_checker.sv
// Port-level assertions for the melody tone player, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mtp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire mtp_pkg::out_item_t out_data
);

  logic [31:0] pend_r;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests taken minus results delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 32'(in_acc) - 32'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != '0)
    else $error("result delivered with no request outstanding");

  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.playing |-> out_data.sample == '0)
    else $error("non-zero sample with playback stopped");

endmodule

bind melody_tone_player_top mtp_checker u_mtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
